// File: hdl/ipid_pkg.sv
// shared types and constants of the two-channel incremental pid block
package ipid_pkg;

   localparam int NUM_CH     = 2;
   localparam int GAIN_W     = 32;
   localparam int POS_W      = 16;
   localparam int ERR_W      = POS_W + 1;
   localparam int DRIVE_W    = 32;
   localparam int DB_W       = 8;
   localparam int PROD_W     = GAIN_W + ERR_W;
   localparam int SUM_W      = PROD_W + 2;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;
   localparam int RSP_DEPTH  = 8;
   localparam int RSP_PTR_W  = 3;
   localparam int RSP_CNT_W  = 4;

   localparam logic CMD_DRIVE = 1'b0;
   localparam logic CMD_CLEAR = 1'b1;

   localparam logic [DB_W-1:0] DEAD_BAND_RESET = 8'd1;

   localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = 32'sh8000_0000;

   typedef enum logic [2:0] {
      REG_GAIN_NOW_CH0,
      REG_GAIN_LAST_CH0,
      REG_GAIN_OLDER_CH0,
      REG_GAIN_NOW_CH1,
      REG_GAIN_LAST_CH1,
      REG_GAIN_OLDER_CH1,
      REG_DEAD_BAND
   } reg_index_type;

   typedef struct packed {
      logic signed [GAIN_W-1:0] now;
      logic signed [GAIN_W-1:0] last;
      logic signed [GAIN_W-1:0] older;
   } gain_set_type;

   typedef struct packed {
      gain_set_type [NUM_CH-1:0] gain;
      logic [DB_W-1:0]           dead_band;
   } cfg_type;

   typedef struct packed {
      logic signed [DRIVE_W-1:0] drive;
      logic signed [ERR_W-1:0]   last_err;
      logic signed [ERR_W-1:0]   older_err;
   } entry_type;

   typedef struct packed {
      logic signed [DRIVE_W-1:0] drive;
      logic                      in_dead_band;
      logic                      saturated;
   } rsp_type;

endpackage

// File: hdl/ipid_csr.sv
// apb register file holding the per-channel gains and the dead band
module ipid_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [ipid_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [ipid_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [ipid_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready,
   output ipid_pkg::cfg_type                   cfg
);

   ipid_pkg::cfg_type       cfg_ff;
   ipid_pkg::cfg_type       cfg_in;
   ipid_pkg::reg_index_type reg_idx;
   logic                    wr_en;

   assign reg_idx    = ipid_pkg::reg_index_type'(csr_paddr[ipid_pkg::CSR_ADDR_W-1:2]);
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            ipid_pkg::REG_GAIN_NOW_CH0:   cfg_in.gain[0].now   = csr_pwdata;
            ipid_pkg::REG_GAIN_LAST_CH0:  cfg_in.gain[0].last  = csr_pwdata;
            ipid_pkg::REG_GAIN_OLDER_CH0: cfg_in.gain[0].older = csr_pwdata;
            ipid_pkg::REG_GAIN_NOW_CH1:   cfg_in.gain[1].now   = csr_pwdata;
            ipid_pkg::REG_GAIN_LAST_CH1:  cfg_in.gain[1].last  = csr_pwdata;
            ipid_pkg::REG_GAIN_OLDER_CH1: cfg_in.gain[1].older = csr_pwdata;
            ipid_pkg::REG_DEAD_BAND:      cfg_in.dead_band     = csr_pwdata[ipid_pkg::DB_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         ipid_pkg::REG_GAIN_NOW_CH0:   csr_prdata = cfg_ff.gain[0].now;
         ipid_pkg::REG_GAIN_LAST_CH0:  csr_prdata = cfg_ff.gain[0].last;
         ipid_pkg::REG_GAIN_OLDER_CH0: csr_prdata = cfg_ff.gain[0].older;
         ipid_pkg::REG_GAIN_NOW_CH1:   csr_prdata = cfg_ff.gain[1].now;
         ipid_pkg::REG_GAIN_LAST_CH1:  csr_prdata = cfg_ff.gain[1].last;
         ipid_pkg::REG_GAIN_OLDER_CH1: csr_prdata = cfg_ff.gain[1].older;
         ipid_pkg::REG_DEAD_BAND: begin
            csr_prdata = {{(ipid_pkg::CSR_DATA_W-ipid_pkg::DB_W){1'b0}}, cfg_ff.dead_band};
         end
         default:                      csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         // gains to zero, dead band in the low bits to its reset value
         cfg_ff <= {{(ipid_pkg::NUM_CH*3*ipid_pkg::GAIN_W){1'b0}}, ipid_pkg::DEAD_BAND_RESET};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: hdl/ipid_rsp_fifo.sv
// result queue between the compute pipeline and the rsp channel
module ipid_rsp_fifo (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push_valid,
   input  ipid_pkg::rsp_type                 push_data,
   output logic                              pop_valid,
   input  logic                              pop_ready,
   output ipid_pkg::rsp_type                 pop_data,
   output logic [ipid_pkg::RSP_CNT_W-1:0]    count
);

   localparam int PTR_W = ipid_pkg::RSP_PTR_W;
   localparam int CNT_W = ipid_pkg::RSP_CNT_W;

   ipid_pkg::rsp_type  q_mem [ipid_pkg::RSP_DEPTH];
   ipid_pkg::rsp_type  head_ff;
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic               pop;

   assign pop_valid = (count_ff != '0);
   assign pop       = pop_valid && pop_ready;
   assign pop_data  = head_ff;
   assign count     = count_ff;
   assign rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;

   always_comb begin
      count_in = count_ff;
      if (push_valid && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!push_valid && pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         q_mem[wr_ptr_ff] <= push_data;
      end
      // head register holds the entry at the read pointer, taking a same-edge write directly
      if (push_valid && (wr_ptr_ff == rd_ptr_in)) begin
         head_ff <= push_data;
      end else begin
         head_ff <= q_mem[rd_ptr_in];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push_valid) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
      end
   end

endmodule

// File: hdl/incremental_pid_two_channel_top.sv
// two-channel velocity-form pid controller, top level
//
// req channel: one transaction per sample gives cmd, channel, target and measured
// position; cmd clear zeroes that channel's stored drive and error history.
// rsp channel: one transaction per request, in request order, with the new drive,
// a dead band flag and a saturation flag.
// csr port: apb registers at 4*i for the six gains (q16.16 by default) and the dead
// band; write them only while no request is outstanding.
// throughput: one request per cycle on any mix of channels, as long as req_ready stays high.
// path: a taken request passes stages a, b and c, then the rsp queue, before rsp_valid.
// the per-channel state sits in a two-entry memory with a registered read; the
// read-modify-write loop closes over three stages by forwarding error history at
// the multiply stage and the stored drive at every stage until the final add.
// the rsp side has an 8-entry queue; req_ready drops when queued plus in-flight
// results reach 8, so a stalled receiver stops intake with room left for the in-flight results.
// reset: gains go to zero, dead band to one, and both channel entries are marked
// empty so they read as zero; no clearing pass, the block is ready right away.
module incremental_pid_two_channel_top #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [ipid_pkg::CSR_ADDR_W-1:0]        csr_paddr,
   input  logic [ipid_pkg::CSR_DATA_W-1:0]        csr_pwdata,
   output logic [ipid_pkg::CSR_DATA_W-1:0]        csr_prdata,
   output logic                                   csr_pready,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_cmd,
   input  logic                                   req_channel,
   input  logic signed [ipid_pkg::POS_W-1:0]      req_target_position,
   input  logic signed [ipid_pkg::POS_W-1:0]      req_measured_position,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [ipid_pkg::DRIVE_W-1:0]    rsp_drive,
   output logic                                   rsp_in_dead_band,
   output logic                                   rsp_saturated
);

   localparam int ERR_W   = ipid_pkg::ERR_W;
   localparam int DRIVE_W = ipid_pkg::DRIVE_W;
   localparam int PROD_W  = ipid_pkg::PROD_W;
   localparam int SUM_W   = ipid_pkg::SUM_W;
   localparam int CNT_W   = ipid_pkg::RSP_CNT_W;
   localparam int PF_W    = SUM_W - FRAC_BITS;
   localparam int S_W     = ((PF_W > DRIVE_W) ? PF_W : DRIVE_W) + 1;

   ipid_pkg::cfg_type cfg;

   ipid_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   logic req_accept;

   // channel state memory, one entry per channel
   ipid_pkg::entry_type               state_mem [ipid_pkg::NUM_CH];
   logic [ipid_pkg::NUM_CH-1:0]       state_vld_ff;
   ipid_pkg::entry_type               rd_entry_ff;
   logic                              rd_hit_ff;

   // stage a: error, dead band, history forwarding, multiplies
   logic                              a_valid_ff;
   logic                              a_cmd_ff;
   logic                              a_ch_ff;
   logic signed [ERR_W-1:0]           a_err_ff;
   ipid_pkg::entry_type               a_mem;
   ipid_pkg::entry_type               a_old;
   ipid_pkg::entry_type               a_new;
   ipid_pkg::gain_set_type            a_gain;
   logic signed [ERR_W-1:0]           a_db_pos;
   logic signed [ERR_W-1:0]           a_db_neg;
   logic                              a_dead;
   logic signed [PROD_W-1:0]          a_p_now;
   logic signed [PROD_W-1:0]          a_p_last;
   logic signed [PROD_W-1:0]          a_p_older;

   // stage b: sum of weighted errors
   logic                              b_valid_ff;
   logic                              b_cmd_ff;
   logic                              b_ch_ff;
   logic                              b_dead_ff;
   ipid_pkg::entry_type               b_entry_ff;
   logic signed [PROD_W-1:0]          b_p_now_ff;
   logic signed [PROD_W-1:0]          b_p_last_ff;
   logic signed [PROD_W-1:0]          b_p_older_ff;
   logic signed [SUM_W-1:0]           b_sum;
   logic signed [DRIVE_W-1:0]         b_drive;
   ipid_pkg::entry_type               b_fwd;

   // stage c: add stored drive, truncate toward zero, saturate
   logic                              c_valid_ff;
   logic                              c_cmd_ff;
   logic                              c_ch_ff;
   logic                              c_dead_ff;
   ipid_pkg::entry_type               c_entry_ff;
   logic signed [PF_W-1:0]            c_pf_ff;
   logic                              c_frac_nz_ff;
   logic signed [DRIVE_W-1:0]         c_drive_old;
   logic signed [S_W-1:0]             c_pf_ext;
   logic signed [S_W-1:0]             c_d_ext;
   logic signed [S_W-1:0]             c_floor;
   logic signed [S_W-1:0]             c_ceil;
   logic signed [S_W-1:0]             c_trunc;
   logic                              c_over;
   logic signed [DRIVE_W-1:0]         c_res;
   logic                              c_compute;
   ipid_pkg::entry_type               c_post;
   ipid_pkg::rsp_type                 c_rsp;

   // entry written to memory at the previous edge
   logic                              w_valid_ff;
   logic                              w_ch_ff;
   ipid_pkg::entry_type               w_entry_ff;

   ipid_pkg::rsp_type                 rsp_data;
   logic [CNT_W-1:0]                  rsp_count;
   logic [CNT_W-1:0]                  in_flight;

   assign in_flight  = CNT_W'(a_valid_ff) + CNT_W'(b_valid_ff) + CNT_W'(c_valid_ff);
   assign req_ready  = (rsp_count + in_flight) < CNT_W'(ipid_pkg::RSP_DEPTH);
   assign req_accept = req_valid && req_ready;

   // ---------------- stage a ----------------
   assign a_mem    = rd_hit_ff ? rd_entry_ff : '0;
   assign a_gain   = cfg.gain[a_ch_ff];
   assign a_db_pos = $signed({{(ERR_W-ipid_pkg::DB_W){1'b0}}, cfg.dead_band});
   assign a_db_neg = -a_db_pos;
   assign a_dead   = (a_err_ff <= a_db_pos) && (a_err_ff >= a_db_neg);

   always_comb begin
      // youngest older transaction on the same channel wins
      a_old = a_mem;
      if (b_valid_ff && (b_ch_ff == a_ch_ff)) begin
         a_old.last_err  = b_entry_ff.last_err;
         a_old.older_err = b_entry_ff.older_err;
      end else if (c_valid_ff && (c_ch_ff == a_ch_ff)) begin
         a_old.last_err  = c_entry_ff.last_err;
         a_old.older_err = c_entry_ff.older_err;
      end else if (w_valid_ff && (w_ch_ff == a_ch_ff)) begin
         a_old.last_err  = w_entry_ff.last_err;
         a_old.older_err = w_entry_ff.older_err;
      end
      // drives of b and c are not known yet, they get patched downstream
      if (w_valid_ff && (w_ch_ff == a_ch_ff)) begin
         a_old.drive = w_entry_ff.drive;
      end
   end

   always_comb begin
      a_new = a_old;
      if (a_cmd_ff == ipid_pkg::CMD_CLEAR) begin
         a_new = '0;
      end else if (!a_dead) begin
         a_new.last_err  = a_err_ff;
         a_new.older_err = a_old.last_err;
      end
   end

   assign a_p_now   = PROD_W'(a_gain.now)   * PROD_W'(a_err_ff);
   assign a_p_last  = PROD_W'(a_gain.last)  * PROD_W'(a_old.last_err);
   assign a_p_older = PROD_W'(a_gain.older) * PROD_W'(a_old.older_err);

   // ---------------- stage b ----------------
   assign b_sum = SUM_W'(b_p_now_ff) + SUM_W'(b_p_last_ff) + SUM_W'(b_p_older_ff);

   always_comb begin
      b_drive = b_entry_ff.drive;
      if (w_valid_ff && (w_ch_ff == b_ch_ff)) begin
         b_drive = w_entry_ff.drive;
      end
   end

   always_comb begin
      b_fwd       = b_entry_ff;
      b_fwd.drive = b_drive;
   end

   // ---------------- stage c ----------------
   always_comb begin
      c_drive_old = c_entry_ff.drive;
      if (w_valid_ff && (w_ch_ff == c_ch_ff)) begin
         c_drive_old = w_entry_ff.drive;
      end
   end

   // floor of the sum is pf + drive; a negative sum with a fraction rounds up
   assign c_pf_ext = S_W'(c_pf_ff);
   assign c_d_ext  = S_W'(c_drive_old);
   assign c_floor  = c_pf_ext + c_d_ext;
   assign c_ceil   = c_pf_ext + c_d_ext + $signed(S_W'(1));
   assign c_trunc  = (c_floor[S_W-1] && c_frac_nz_ff) ? c_ceil : c_floor;
   assign c_over   = !((&c_trunc[S_W-1:DRIVE_W-1]) || !(|c_trunc[S_W-1:DRIVE_W-1]));

   always_comb begin
      if (!c_over) begin
         c_res = c_trunc[DRIVE_W-1:0];
      end else if (c_trunc[S_W-1]) begin
         c_res = ipid_pkg::DRIVE_MIN;
      end else begin
         c_res = ipid_pkg::DRIVE_MAX;
      end
   end

   assign c_compute = (c_cmd_ff == ipid_pkg::CMD_DRIVE) && !c_dead_ff;

   always_comb begin
      c_post       = c_entry_ff;
      c_post.drive = c_drive_old;
      if (c_cmd_ff == ipid_pkg::CMD_CLEAR) begin
         c_post.drive = '0;
      end else if (c_compute) begin
         c_post.drive = c_res;
      end
   end

   always_comb begin
      c_rsp.drive        = c_compute ? c_res : '0;
      c_rsp.in_dead_band = (c_cmd_ff == ipid_pkg::CMD_DRIVE) && c_dead_ff;
      c_rsp.saturated    = c_compute && c_over;
   end

   // ---------------- state memory ----------------
   always_ff @(posedge clock) begin
      if (c_valid_ff) begin
         state_mem[c_ch_ff] <= c_post;
      end
      if (req_accept) begin
         rd_entry_ff <= state_mem[req_channel];
         rd_hit_ff   <= state_vld_ff[req_channel];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_vld_ff <= '0;
      end else if (c_valid_ff) begin
         state_vld_ff[c_ch_ff] <= 1'b1;
      end
   end

   // ---------------- pipeline registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         w_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= req_accept;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         w_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         a_cmd_ff <= req_cmd;
         a_ch_ff  <= req_channel;
         a_err_ff <= ERR_W'(req_target_position) - ERR_W'(req_measured_position);
      end
      b_cmd_ff     <= a_cmd_ff;
      b_ch_ff      <= a_ch_ff;
      b_dead_ff    <= a_dead;
      b_entry_ff   <= a_new;
      b_p_now_ff   <= a_p_now;
      b_p_last_ff  <= a_p_last;
      b_p_older_ff <= a_p_older;

      c_cmd_ff           <= b_cmd_ff;
      c_ch_ff            <= b_ch_ff;
      c_dead_ff          <= b_dead_ff;
      c_entry_ff         <= b_fwd;
      c_pf_ff            <= b_sum[SUM_W-1:FRAC_BITS];
      c_frac_nz_ff       <= |b_sum[FRAC_BITS-1:0];

      w_ch_ff    <= c_ch_ff;
      w_entry_ff <= c_post;
   end

   // ---------------- result queue ----------------
   ipid_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (c_valid_ff),
      .push_data  (c_rsp),
      .pop_valid  (rsp_valid),
      .pop_ready  (rsp_ready),
      .pop_data   (rsp_data),
      .count      (rsp_count)
   );

   assign rsp_drive        = rsp_data.drive;
   assign rsp_in_dead_band = rsp_data.in_dead_band;
   assign rsp_saturated    = rsp_data.saturated;

endmodule

// File: hdl/ipid_checker.sv
// port-level assertions for the pid top level and their bind
module ipid_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_valid,
   input logic                                   req_ready,
   input logic                                   rsp_valid,
   input logic                                   rsp_ready,
   input logic signed [ipid_pkg::DRIVE_W-1:0]    rsp_drive,
   input logic                                   rsp_in_dead_band,
   input logic                                   rsp_saturated
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_drive)
         && $stable(rsp_in_dead_band) && $stable(rsp_saturated))
      else $error("rsp transaction changed while stalled");

   // nothing comes out right after reset, and intake is open
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("rsp valid or req not ready after reset");

   a_dead_band_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_in_dead_band |-> (rsp_drive == '0) && !rsp_saturated)
      else $error("dead band transaction with nonzero drive or saturation");

   a_sat_at_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |->
         (rsp_drive == ipid_pkg::DRIVE_MAX) || (rsp_drive == ipid_pkg::DRIVE_MIN))
      else $error("saturated drive not at a limit");

endmodule

bind incremental_pid_two_channel_top ipid_checker u_ipid_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_drive        (rsp_drive),
   .rsp_in_dead_band (rsp_in_dead_band),
   .rsp_saturated    (rsp_saturated)
);

// File: sim/tb.sv
// testbench for the two-channel incremental pid block: directed table, random phases, predictor
`timescale 1ns / 100ps

module tb;

   localparam int FRAC        = 16;
   localparam int NUM_PHASES  = 8;
   localparam int PHASE_ITEMS = 128;
   localparam int HOLD_PHASE  = 2;
   localparam int HOLD_CYCLES = 300;
   localparam int SETTLE      = 8;
   localparam int QUIET_LIMIT = 2000;

   localparam int NUM_CH     = ipid_pkg::NUM_CH;
   localparam int GAIN_W     = ipid_pkg::GAIN_W;
   localparam int POS_W      = ipid_pkg::POS_W;
   localparam int ERR_W      = ipid_pkg::ERR_W;
   localparam int DRIVE_W    = ipid_pkg::DRIVE_W;
   localparam int DB_W       = ipid_pkg::DB_W;
   localparam int CSR_DATA_W = ipid_pkg::CSR_DATA_W;
   localparam int CSR_ADDR_W = ipid_pkg::CSR_ADDR_W;

   localparam logic [2:0] REG_UNUSED = 3'd7;
   localparam logic signed [GAIN_W-1:0] GAIN_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [GAIN_W-1:0] GAIN_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic                    is_write;
      logic [2:0]              addr;
      logic [CSR_DATA_W-1:0]   value;
      logic                    cmd;
      logic                    ch;
      logic signed [POS_W-1:0] tgt;
      logic signed [POS_W-1:0] meas;
      logic                    typed;
      ipid_pkg::rsp_type       want;
   } plan_row_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          csr_psel = 1'b0;
   logic                          csr_penable = 1'b0;
   logic                          csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]         csr_paddr = '0;
   logic [CSR_DATA_W-1:0]         csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]         csr_prdata;
   logic                          csr_pready;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic                          req_cmd = ipid_pkg::CMD_DRIVE;
   logic                          req_channel = 1'b0;
   logic signed [POS_W-1:0]       req_target_position = '0;
   logic signed [POS_W-1:0]       req_measured_position = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic signed [DRIVE_W-1:0]     rsp_drive;
   logic                          rsp_in_dead_band;
   logic                          rsp_saturated;

   // predictor copy of the configuration and of the per-channel history
   logic signed [GAIN_W-1:0]  gain_tab [NUM_CH][3];
   logic [DB_W-1:0]           band = ipid_pkg::DEAD_BAND_RESET;
   logic signed [DRIVE_W-1:0] held_drive [NUM_CH];
   logic signed [ERR_W-1:0]   prev_err [NUM_CH];
   logic signed [ERR_W-1:0]   prev2_err [NUM_CH];

   ipid_pkg::rsp_type pending_drive [$];
   int                mismatch_count = 0;
   int                quiet_cycles = 0;
   bit                tx_idle = 1'b1;
   bit                rx_idle = 1'b1;
   bit                hold_rsp = 1'b0;

   incremental_pid_two_channel_top #(.FRAC_BITS(FRAC)) i_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      for (int c = 0; c < NUM_CH; c++) begin
         for (int k = 0; k < 3; k++) gain_tab[c][k] = '0;
         held_drive[c] = '0;
         prev_err[c]   = '0;
         prev2_err[c]  = '0;
      end
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
      mismatch_count++;
   endtask

   // velocity-form update: weighted errors plus stored drive, truncate toward zero, clamp
   function automatic ipid_pkg::rsp_type next_drive(logic cmd, logic ch,
                                                    logic signed [POS_W-1:0] tgt,
                                                    logic signed [POS_W-1:0] meas);
      ipid_pkg::rsp_type r;
      int      e;
      int      db;
      longint  acc;
      longint  mag;
      longint  res;
      logic    neg;
      r = '0;
      if (cmd == ipid_pkg::CMD_CLEAR) begin
         held_drive[ch] = '0;
         prev_err[ch]   = '0;
         prev2_err[ch]  = '0;
         return r;
      end
      e  = int'(tgt) - int'(meas);
      db = int'(band);
      if (e <= db && e >= -db) begin
         r.in_dead_band = 1'b1;
         return r;
      end
      acc = longint'(gain_tab[ch][0]) * e + longint'(gain_tab[ch][1]) * longint'(prev_err[ch])
          + longint'(gain_tab[ch][2]) * longint'(prev2_err[ch])
          + (longint'(held_drive[ch]) <<< FRAC);
      neg = acc < 0;
      mag = neg ? -acc : acc;
      mag = mag >> FRAC;
      if (neg) begin
         if (mag > 64'sh8000_0000) begin
            mag = 64'sh8000_0000;
            r.saturated = 1'b1;
         end
         res = -mag;
      end else begin
         if (mag > 64'sh7FFF_FFFF) begin
            mag = 64'sh7FFF_FFFF;
            r.saturated = 1'b1;
         end
         res = mag;
      end
      prev2_err[ch]  = prev_err[ch];
      prev_err[ch]   = e[ERR_W-1:0];
      held_drive[ch] = res[DRIVE_W-1:0];
      r.drive        = res[DRIVE_W-1:0];
      return r;
   endfunction

   function automatic void apply_register(logic [2:0] idx, logic [CSR_DATA_W-1:0] value);
      if (idx <= ipid_pkg::REG_GAIN_OLDER_CH1)
         gain_tab[idx / 3][idx % 3] = value;
      else if (idx == ipid_pkg::REG_DEAD_BAND)
         band = value[DB_W-1:0];
   endfunction

   // psel stays up after the access phase so back-to-back accesses need one nba per step
   task automatic csr_access(input logic wr, input logic [2:0] idx,
                             input logic [CSR_DATA_W-1:0] value,
                             output logic [CSR_DATA_W-1:0] rd);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rd = csr_prdata;
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [CSR_DATA_W-1:0] value);
      logic [CSR_DATA_W-1:0] rd;
      logic [CSR_DATA_W-1:0] want;
      req_valid <= 1'b0;
      while (pending_drive.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      csr_access(1'b1, idx, value, rd);
      apply_register(idx, value);
      if (idx <= ipid_pkg::REG_DEAD_BAND) begin
         csr_access(1'b0, idx, '0, rd);
         want = (idx == ipid_pkg::REG_DEAD_BAND) ?
                {{(CSR_DATA_W-DB_W){1'b0}}, value[DB_W-1:0]} : value;
         if (rd !== want) report_mismatch("register readback", rd, want);
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // valid stays high into the next transaction when no gap is drawn
   task automatic send_item(input logic cmd, input logic ch, input logic signed [POS_W-1:0] tgt,
                            input logic signed [POS_W-1:0] meas, input logic typed,
                            input ipid_pkg::rsp_type want);
      ipid_pkg::rsp_type predicted;
      int      gap;
      req_valid             <= 1'b1;
      req_cmd               <= cmd;
      req_channel           <= ch;
      req_target_position   <= tgt;
      req_measured_position <= meas;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = next_drive(cmd, ch, tgt, meas);
      pending_drive.push_back(typed ? want : predicted);
      gap = tx_idle ? $urandom_range(0, 11) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic plan_row_type reg_row(logic [2:0] addr, logic [CSR_DATA_W-1:0] value);
      plan_row_type r;
      r          = '0;
      r.is_write = 1'b1;
      r.addr     = addr;
      r.value    = value;
      return r;
   endfunction

   function automatic plan_row_type sample_row(logic cmd, logic ch,
                                               logic signed [POS_W-1:0] tgt,
                                               logic signed [POS_W-1:0] meas);
      plan_row_type r;
      r      = '0;
      r.cmd  = cmd;
      r.ch   = ch;
      r.tgt  = tgt;
      r.meas = meas;
      return r;
   endfunction

   function automatic plan_row_type known_row(logic cmd, logic ch, logic signed [POS_W-1:0] tgt,
                                              logic signed [POS_W-1:0] meas,
                                              logic signed [DRIVE_W-1:0] drive, logic db,
                                              logic sat);
      plan_row_type r;
      r                   = sample_row(cmd, ch, tgt, meas);
      r.typed             = 1'b1;
      r.want.drive        = drive;
      r.want.in_dead_band = db;
      r.want.saturated    = sat;
      return r;
   endfunction

   function automatic logic [GAIN_W-1:0] random_gain(int phase);
      if (phase == 0) return GAIN_MAX;
      if (phase == 1) return GAIN_MIN;
      case ($urandom_range(0, 7))
         0: return GAIN_MAX;
         1: return GAIN_MIN;
         2: return '0;
         3: return $urandom;
         default: return $urandom_range(0, 1 << 19) - (1 << 18);
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] random_band(int phase);
      if (phase == 0) return 0;
      if (phase == 1) return 255;
      case ($urandom_range(0, 5))
         0: return 0;
         1: return 255;
         2: return $urandom_range(0, 255);
         default: return $urandom_range(0, 8);
      endcase
   endfunction

   initial begin : stimulus
      plan_row_type            plan [$];
      logic                    cmd;
      logic                    ch;
      logic signed [POS_W-1:0] tgt;
      logic signed [POS_W-1:0] meas;
      int                      offset;

      // zero gains and dead band of one straight after reset
      plan.push_back(known_row(ipid_pkg::CMD_DRIVE, 1'b0, 16'sh0000, 16'sh0000, 0, 1'b1, 1'b0));
      plan.push_back(known_row(ipid_pkg::CMD_DRIVE, 1'b1, 16'sh0001, 16'sh0000, 0, 1'b1, 1'b0));
      plan.push_back(known_row(ipid_pkg::CMD_DRIVE, 1'b0, 16'shFFFF, 16'sh0000, 0, 1'b1, 1'b0));
      plan.push_back(known_row(ipid_pkg::CMD_DRIVE, 1'b0, 16'sh7FFF, 16'sh8000, 0, 1'b0, 1'b0));
      plan.push_back(known_row(ipid_pkg::CMD_DRIVE, 1'b1, 16'sh8000, 16'sh7FFF, 0, 1'b0, 1'b0));
      plan.push_back(known_row(ipid_pkg::CMD_CLEAR, 1'b0, 16'sh7FFF, 16'sh7FFF, 0, 1'b0, 1'b0));
      plan.push_back(reg_row(ipid_pkg::REG_GAIN_NOW_CH0, GAIN_MAX));
      plan.push_back(reg_row(ipid_pkg::REG_GAIN_LAST_CH0, GAIN_MIN));
      plan.push_back(reg_row(ipid_pkg::REG_GAIN_OLDER_CH0, 32'h0001_0000));
      plan.push_back(reg_row(ipid_pkg::REG_GAIN_NOW_CH1, 32'hFFFF_0000));
      plan.push_back(reg_row(ipid_pkg::REG_GAIN_LAST_CH1, 32'h0000_028F));
      plan.push_back(reg_row(ipid_pkg::REG_GAIN_OLDER_CH1, 32'h0002_0000));
      plan.push_back(reg_row(ipid_pkg::REG_DEAD_BAND, 32'd0));
      // write past the last register must leave everything alone
      plan.push_back(reg_row(REG_UNUSED, 32'hFFFF_FFFF));
      plan.push_back(sample_row(ipid_pkg::CMD_DRIVE, 1'b0, 16'sh7FFF, 16'sh8000));
      plan.push_back(sample_row(ipid_pkg::CMD_DRIVE, 1'b0, 16'sh7FFF, 16'sh8000));
      plan.push_back(sample_row(ipid_pkg::CMD_DRIVE, 1'b0, 16'sh8000, 16'sh7FFF));
      plan.push_back(known_row(ipid_pkg::CMD_DRIVE, 1'b0, 16'sh1234, 16'sh1234, 0, 1'b1, 1'b0));
      plan.push_back(known_row(ipid_pkg::CMD_CLEAR, 1'b0, 16'sh8000, 16'sh7FFF, 0, 1'b0, 1'b0));
      plan.push_back(sample_row(ipid_pkg::CMD_DRIVE, 1'b1, 16'sh0001, 16'sh0000));
      plan.push_back(sample_row(ipid_pkg::CMD_DRIVE, 1'b1, 16'sh8000, 16'sh7FFF));
      plan.push_back(sample_row(ipid_pkg::CMD_DRIVE, 1'b1, 16'sh8000, 16'sh7FFF));
      plan.push_back(reg_row(ipid_pkg::REG_DEAD_BAND, 32'd255));
      plan.push_back(known_row(ipid_pkg::CMD_DRIVE, 1'b1, 16'sd255, 16'sd0, 0, 1'b1, 1'b0));
      plan.push_back(known_row(ipid_pkg::CMD_DRIVE, 1'b1, -16'sd255, 16'sd0, 0, 1'b1, 1'b0));
      plan.push_back(sample_row(ipid_pkg::CMD_DRIVE, 1'b0, 16'sd256, 16'sd0));
      plan.push_back(sample_row(ipid_pkg::CMD_DRIVE, 1'b0, 16'sd0, 16'sd256));
      plan.push_back(known_row(ipid_pkg::CMD_CLEAR, 1'b1, 16'sh0000, 16'sh0000, 0, 1'b0, 1'b0));

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].is_write)
            csr_write(plan[i].addr, plan[i].value);
         else
            send_item(plan[i].cmd, plan[i].ch, plan[i].tgt, plan[i].meas, plan[i].typed,
                      plan[i].want);
      end

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         for (int k = 0; k < 7; k++)
            csr_write(3'(k), (k < 6) ? random_gain(phase) : random_band(phase));
         tx_idle = (phase != HOLD_PHASE) && ($urandom_range(0, 3) != 0);
         rx_idle = $urandom_range(0, 3) != 0;
         if (phase == HOLD_PHASE) hold_rsp = 1'b1;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            cmd = ($urandom_range(0, 11) == 0) ? ipid_pkg::CMD_CLEAR : ipid_pkg::CMD_DRIVE;
            ch  = 1'($urandom_range(0, 1));
            tgt = POS_W'($urandom);
            case ($urandom_range(0, 3))
               0: meas = POS_W'($urandom);
               3: begin
                  tgt  = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                  meas = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
               end
               default: begin
                  // errors straddling the dead band edge
                  offset = int'($urandom_range(0, 2 * band + 6)) - int'(band) - 3;
                  meas   = tgt - offset[POS_W-1:0];
               end
            endcase
            send_item(cmd, ch, tgt, meas, 1'b0, '0);
         end
      end

      req_valid <= 1'b0;
      while (pending_drive.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (mismatch_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   initial begin : result_side
      int                stall;
      ipid_pkg::rsp_type want;
      @(posedge clock);
      forever begin
         if (hold_rsp) begin
            // long stall so the result queue fills and req_ready drops
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end
         stall = rx_idle ? $urandom_range(0, 11) : 0;
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         if (pending_drive.size() == 0) begin
            report_mismatch("transaction with no request pending", rsp_drive, 0);
         end else begin
            want = pending_drive.pop_front();
            if (rsp_drive !== want.drive)
               report_mismatch("drive", rsp_drive, want.drive);
            if (rsp_in_dead_band !== want.in_dead_band)
               report_mismatch("in_dead_band", rsp_in_dead_band, want.in_dead_band);
            if (rsp_saturated !== want.saturated)
               report_mismatch("saturated", rsp_saturated, want.saturated);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_psel)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

endmodule

// File: incremental_pid_two_channel_top.f
hdl/ipid_pkg.sv
hdl/ipid_csr.sv
hdl/ipid_rsp_fifo.sv
hdl/incremental_pid_two_channel_top.sv
hdl/ipid_checker.sv
sim/tb.sv
